### hdl/rrs_pkg.sv
// package for the round-robin sleep scheduler
// holds sizes, operation codes, controller states and command/status structs
// no dependencies
package rrs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
    localparam int SLEEP_W   = 32;
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 4;
    localparam int NCOUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_SLEEP     = 2'd1,
        OP_LOAD      = 2'd2,
        OP_SET_COUNT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic apply;
        logic mod_step;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic few_slots;
        logic mod_done;
        logic scan_last;
    } t_sts;

endpackage

### hdl/rrs_datapath.sv
// datapath of the round-robin sleep scheduler: slot table, scan walker, result register
// driven by rrs_ctrl through rrs_pkg::t_cmd, reports through rrs_pkg::t_sts
// depends on rrs_pkg
module rrs_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrs_pkg::t_cmd                 i_cmd,
    output rrs_pkg::t_sts                 o_sts,
    input  logic [rrs_pkg::OP_W-1:0]      i_operation,
    input  logic [rrs_pkg::SLOT_W-1:0]    i_slot,
    input  logic [rrs_pkg::SLEEP_W-1:0]   i_sleep_value,
    input  logic                          i_is_boot_task,
    input  logic                          i_awaiting_start,
    input  logic                          i_is_running,
    input  logic [rrs_pkg::NCOUNT_W-1:0]  i_new_count,
    output logic                          o_switched,
    output logic [rrs_pkg::SLOT_W-1:0]    o_next_slot
);

    // latched request
    rrs_pkg::t_op                  r_op;
    logic [rrs_pkg::SLOT_W-1:0]    r_slot;
    logic [rrs_pkg::SLEEP_W-1:0]   r_sval;
    logic                          r_boot_in;
    logic                          r_pend_in;
    logic                          r_run_in;
    logic [rrs_pkg::NCOUNT_W-1:0]  r_newcnt;

    // slot table
    logic [rrs_pkg::SLEEP_W-1:0]   r_sleep [rrs_pkg::MAX_TASKS];
    logic [rrs_pkg::MAX_TASKS-1:0] r_boot;
    logic [rrs_pkg::MAX_TASKS-1:0] r_pend;
    logic [rrs_pkg::MAX_TASKS-1:0] r_run;
    logic [rrs_pkg::IDX_W-1:0]     r_cur;
    logic [rrs_pkg::COUNT_W-1:0]   r_count;

    // scan walker
    logic [rrs_pkg::COUNT_W-1:0]   r_idx;
    logic [rrs_pkg::COUNT_W-1:0]   r_visit;
    logic                          r_found;
    logic [rrs_pkg::IDX_W-1:0]     r_cand;

    logic [rrs_pkg::SLOT_W-1:0]    r_next_slot;
    logic                          r_switched;

    logic [rrs_pkg::IDX_W-1:0]     w_ix;
    logic [rrs_pkg::SLEEP_W-1:0]   w_cnt;
    logic                          w_ready;
    logic [rrs_pkg::COUNT_W-1:0]   w_idx_inc;
    logic                          w_sw;
    logic [rrs_pkg::COUNT_W-1:0]   w_slot_ext;

    assign w_ix       = r_idx[rrs_pkg::IDX_W-1:0];
    assign w_cnt      = r_sleep[w_ix];
    assign w_ready    = !r_boot[w_ix] && !r_pend[w_ix] && r_run[w_ix] &&
                        (w_cnt <= rrs_pkg::SLEEP_W'(1));
    assign w_idx_inc  = r_idx + rrs_pkg::COUNT_W'(1);
    assign w_sw       = r_found && (r_cand != r_cur);
    assign w_slot_ext = rrs_pkg::COUNT_W'(r_slot);

    assign o_sts.is_tick   = (r_op == rrs_pkg::OP_TICK);
    assign o_sts.few_slots = (r_count < rrs_pkg::COUNT_W'(2));
    assign o_sts.mod_done  = (r_idx < r_count);
    assign o_sts.scan_last = (r_visit == r_count - rrs_pkg::COUNT_W'(1));

    assign o_switched  = r_switched;
    assign o_next_slot = r_next_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= rrs_pkg::t_op'(i_operation);
            r_slot    <= i_slot;
            r_sval    <= i_sleep_value;
            r_boot_in <= i_is_boot_task;
            r_pend_in <= i_awaiting_start;
            r_run_in  <= i_is_running;
            r_newcnt  <= i_new_count;
        end
        if (i_cmd.apply) begin
            r_idx   <= rrs_pkg::COUNT_W'(r_cur) + rrs_pkg::COUNT_W'(1);
            r_visit <= '0;
        end else if (i_cmd.mod_step) begin
            r_idx <= r_idx - r_count;
        end else if (i_cmd.scan_step) begin
            r_idx   <= (w_idx_inc == r_count) ? '0 : w_idx_inc;
            r_visit <= r_visit + rrs_pkg::COUNT_W'(1);
        end
        if (i_cmd.scan_step && w_ready && !r_found) begin
            r_cand <= w_ix;
        end
        if (i_cmd.out_load) begin
            r_switched  <= w_sw;
            r_next_slot <= rrs_pkg::SLOT_W'(w_sw ? r_cand : r_cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rrs_pkg::MAX_TASKS; k++) begin
                r_sleep[k] <= '0;
            end
            r_boot  <= '0;
            r_pend  <= '0;
            r_run   <= '0;
            r_cur   <= '0;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_found <= 1'b0;
                case (r_op)
                    rrs_pkg::OP_SLEEP: begin
                        r_sleep[r_cur] <= r_sval;
                    end
                    rrs_pkg::OP_LOAD: begin
                        if (w_slot_ext < rrs_pkg::COUNT_W'(rrs_pkg::MAX_TASKS)) begin
                            r_boot[w_slot_ext[rrs_pkg::IDX_W-1:0]] <= r_boot_in;
                            r_pend[w_slot_ext[rrs_pkg::IDX_W-1:0]] <= r_pend_in;
                            r_run[w_slot_ext[rrs_pkg::IDX_W-1:0]]  <= r_run_in;
                        end
                    end
                    rrs_pkg::OP_SET_COUNT: begin
                        if (r_newcnt > rrs_pkg::NCOUNT_W'(rrs_pkg::MAX_TASKS)) begin
                            r_count <= rrs_pkg::COUNT_W'(rrs_pkg::MAX_TASKS);
                        end else begin
                            r_count <= rrs_pkg::COUNT_W'(r_newcnt);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.scan_step) begin
                if (w_cnt != '0) begin
                    r_sleep[w_ix] <= w_cnt - rrs_pkg::SLEEP_W'(1);
                end
                if (w_ready) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.out_load && w_sw) begin
                r_cur <= r_cand;
            end
        end
    end

endmodule

### hdl/rrs_ctrl.sv
// controller of the round-robin sleep scheduler: sequences request, modulo walk, scan and result
// drives rrs_datapath through rrs_pkg::t_cmd, owns both handshakes
// depends on rrs_pkg
module rrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  rrs_pkg::t_sts i_sts,
    output rrs_pkg::t_cmd o_cmd
);

    rrs_pkg::t_state r_state;
    rrs_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    assign o_in_stall  = (r_state != rrs_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            rrs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = rrs_pkg::ST_EXEC;
                end
            end
            rrs_pkg::ST_EXEC: begin
                o_cmd.apply = 1'b1;
                if (i_sts.is_tick && !i_sts.few_slots) begin
                    n_state = rrs_pkg::ST_MOD;
                end else begin
                    n_state = rrs_pkg::ST_DONE;
                end
            end
            rrs_pkg::ST_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = rrs_pkg::ST_SCAN;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            rrs_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = rrs_pkg::ST_DONE;
                end
            end
            rrs_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = rrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/round_robin_sleep_scheduler.sv
// top level of the round-robin sleep scheduler
// instantiates rrs_ctrl and rrs_datapath, depends on rrs_pkg
//
//   channel  | valid        | stall        | payload
//   request  | i_in_valid   | o_in_stall   | i_operation .. i_new_count
//   result   | o_out_valid  | i_out_stall  | o_switched, o_next_slot
//
// load, sleep and set-count requests go through ST_EXEC and ST_DONE to the result,
// as does a tick over fewer than two slots; a tick over two or more first walks
// the start slot modulo the count in ST_MOD, then scans one slot per cycle in ST_SCAN
// reset clears the slot table, current slot and count
// a stalled result waits in the output register while the next request is taken
module round_robin_sleep_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rrs_pkg::OP_W-1:0]      i_operation,
    input  logic [rrs_pkg::SLOT_W-1:0]    i_slot,
    input  logic [rrs_pkg::SLEEP_W-1:0]   i_sleep_value,
    input  logic                          i_is_boot_task,
    input  logic                          i_awaiting_start,
    input  logic                          i_is_running,
    input  logic [rrs_pkg::NCOUNT_W-1:0]  i_new_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_switched,
    output logic [rrs_pkg::SLOT_W-1:0]    o_next_slot
);

    rrs_pkg::t_cmd w_cmd;
    rrs_pkg::t_sts w_sts;

    rrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rrs_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_operation      (i_operation),
        .i_slot           (i_slot),
        .i_sleep_value    (i_sleep_value),
        .i_is_boot_task   (i_is_boot_task),
        .i_awaiting_start (i_awaiting_start),
        .i_is_running     (i_is_running),
        .i_new_count      (i_new_count),
        .o_switched       (o_switched),
        .o_next_slot      (o_next_slot)
    );

endmodule
